/* rtl/assert_macros.svh */
// Assertion macros for the hierarchical event queue unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

/* rtl/heq_pkg.sv */
// Types, constants and state codes of the hierarchical event queue unit
package heq_pkg;
   localparam int NUM_CHILDREN = 4;
   localparam int CHILD_DEPTH = 16;
   localparam int PARENT_DEPTH = 64;
   localparam int EVENT_WIDTH = 32;
   localparam int CW = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1;
   localparam int CAW = $clog2(CHILD_DEPTH);
   localparam int PAW = $clog2(PARENT_DEPTH);
   localparam int KAW = CW + CAW;
   localparam int PCW = PAW + 1;
   localparam int KCW = CAW + 1;
   localparam int PEW = 1 + CW + EVENT_WIDTH;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic MODE_PUT = 1'b0;

   typedef struct packed {
      logic mode;
      logic [2:0] queue_id;
      logic [31:0] event_data;
   } req_type;

   typedef struct packed {
      logic [31:0] result_event;
      logic result_valid;
      logic [2:0] source_queue;
      logic notify;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic is_link;
      logic [CW-1:0] child;
      logic [EVENT_WIDTH-1:0] ev;
   } pent_type;

   typedef enum logic [2:0] {
      S_IDLE, S_PREAD, S_PWAIT, S_KREAD, S_KWAIT
   } state_type;

   typedef struct packed {
      logic we;
      logic [PAW-1:0] waddr;
      pent_type wdata;
      logic [PAW-1:0] raddr;
   } pmem_ctl_type;

   typedef struct packed {
      logic we;
      logic [KAW-1:0] waddr;
      logic [EVENT_WIDTH-1:0] wdata;
      logic [KAW-1:0] raddr;
   } kmem_ctl_type;
endpackage

/* rtl/heq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read
module heq_ram #(
   parameter int WIDTH = 8,
   parameter int AW = 4
) (
   input logic clock,
   input logic we,
   input logic [AW-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [AW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [2**AW];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* rtl/heq_ctrl.sv */
// Sequencer and queue pointers of the hierarchical event queue unit
module heq_ctrl (
   input logic clock,
   input logic reset,
   input logic start,
   input heq_pkg::req_type req,
   input logic notify_enable,
   output logic busy,
   output logic done,
   output heq_pkg::rsp_type rsp,
   output heq_pkg::pmem_ctl_type pctl,
   output heq_pkg::kmem_ctl_type kctl,
   input heq_pkg::pent_type prdata,
   input logic [heq_pkg::EVENT_WIDTH-1:0] krdata
);
   localparam int NC = heq_pkg::NUM_CHILDREN;
   heq_pkg::state_type state_ff, state_in;
   logic [heq_pkg::PAW-1:0] phead_ff, phead_in, ptail_ff, ptail_in;
   logic [heq_pkg::PCW-1:0] pcount_ff, pcount_in;
   logic [heq_pkg::CAW-1:0] khead_ff [NC], khead_in [NC], ktail_ff [NC], ktail_in [NC];
   logic [heq_pkg::KCW-1:0] kcount_ff [NC], kcount_in [NC];
   logic [heq_pkg::PCW-1:0] kskip_ff [NC], kskip_in [NC];
   logic [heq_pkg::CW-1:0] cur_ff, cur_in;
   logic [2:0] src_ff, src_in;
   heq_pkg::rsp_type rsp_ff, rsp_in;
   logic done_ff, done_in;
   logic [heq_pkg::CW-1:0] qc, lc;
   logic qok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= heq_pkg::S_IDLE;
         phead_ff <= '0;
         ptail_ff <= '0;
         pcount_ff <= '0;
         done_ff <= 1'b0;
         for (int i = 0; i < NC; i++) begin
            khead_ff[i] <= '0;
            ktail_ff[i] <= '0;
            kcount_ff[i] <= '0;
            kskip_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         phead_ff <= phead_in;
         ptail_ff <= ptail_in;
         pcount_ff <= pcount_in;
         done_ff <= done_in;
         khead_ff <= khead_in;
         ktail_ff <= ktail_in;
         kcount_ff <= kcount_in;
         kskip_ff <= kskip_in;
      end
      cur_ff <= cur_in;
      src_ff <= src_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      phead_in = phead_ff;
      ptail_in = ptail_ff;
      pcount_in = pcount_ff;
      khead_in = khead_ff;
      ktail_in = ktail_ff;
      kcount_in = kcount_ff;
      kskip_in = kskip_ff;
      cur_in = cur_ff;
      src_in = src_ff;
      rsp_in = rsp_ff;
      done_in = 1'b0;
      pctl = '0;
      kctl = '0;
      qc = heq_pkg::CW'(req.queue_id - 3'd1);
      qok = (32'(req.queue_id) <= NC);
      lc = prdata.child;
      pctl.raddr = phead_ff;
      kctl.raddr = {cur_ff, khead_ff[cur_ff]};
      unique case (state_ff)
         heq_pkg::S_IDLE: begin
            if (start && !done_ff) begin
               rsp_in = '0;
               if (!qok) begin
                  rsp_in.status = (req.mode == heq_pkg::MODE_PUT) ? heq_pkg::ST_FULL
                                                                  : heq_pkg::ST_EMPTY;
                  done_in = 1'b1;
               end else if (req.mode == heq_pkg::MODE_PUT) begin
                  done_in = 1'b1;
                  if (32'(pcount_ff) >= heq_pkg::PARENT_DEPTH) begin
                     rsp_in.status = heq_pkg::ST_FULL;
                  end else if (req.queue_id == 3'd0) begin
                     pctl.we = 1'b1;
                     pctl.waddr = ptail_ff;
                     pctl.wdata = '{1'b0, '0, heq_pkg::EVENT_WIDTH'(req.event_data)};
                     ptail_in = ptail_ff + 1'b1;
                     pcount_in = pcount_ff + 1'b1;
                  end else if (32'(kcount_ff[qc]) >= heq_pkg::CHILD_DEPTH) begin
                     rsp_in.status = heq_pkg::ST_FULL;
                  end else begin
                     kctl.we = 1'b1;
                     kctl.waddr = {qc, ktail_ff[qc]};
                     kctl.wdata = heq_pkg::EVENT_WIDTH'(req.event_data);
                     ktail_in[qc] = ktail_ff[qc] + 1'b1;
                     kcount_in[qc] = kcount_ff[qc] + 1'b1;
                     pctl.we = 1'b1;
                     pctl.waddr = ptail_ff;
                     pctl.wdata = '{1'b1, qc, '0};
                     ptail_in = ptail_ff + 1'b1;
                     pcount_in = pcount_ff + 1'b1;
                     rsp_in.notify = notify_enable;
                  end
               end else if (req.queue_id == 3'd0) begin
                  state_in = heq_pkg::S_PREAD;
               end else if (kcount_ff[qc] == '0) begin
                  rsp_in.status = heq_pkg::ST_EMPTY;
                  done_in = 1'b1;
               end else begin
                  cur_in = qc;
                  src_in = req.queue_id;
                  kskip_in[qc] = kskip_ff[qc] + 1'b1;
                  state_in = heq_pkg::S_KREAD;
               end
            end
         end
         heq_pkg::S_PREAD: begin
            if (pcount_ff == '0) begin
               rsp_in.status = heq_pkg::ST_EMPTY;
               done_in = 1'b1;
               state_in = heq_pkg::S_IDLE;
            end else begin
               state_in = heq_pkg::S_PWAIT;
            end
         end
         heq_pkg::S_PWAIT: begin
            phead_in = phead_ff + 1'b1;
            pcount_in = pcount_ff - 1'b1;
            pctl.raddr = phead_ff + 1'b1;
            if (!prdata.is_link) begin
               rsp_in.result_event = 32'(prdata.ev);
               rsp_in.result_valid = 1'b1;
               done_in = 1'b1;
               state_in = heq_pkg::S_IDLE;
            end else if (kskip_ff[lc] != '0) begin
               kskip_in[lc] = kskip_ff[lc] - 1'b1;
               if (pcount_ff == heq_pkg::PCW'(1)) begin
                  rsp_in.status = heq_pkg::ST_EMPTY;
                  done_in = 1'b1;
                  state_in = heq_pkg::S_IDLE;
               end
            end else if (kcount_ff[lc] == '0) begin
               rsp_in.status = heq_pkg::ST_EMPTY;
               done_in = 1'b1;
               state_in = heq_pkg::S_IDLE;
            end else begin
               cur_in = lc;
               src_in = 3'(lc) + 3'd1;
               state_in = heq_pkg::S_KREAD;
            end
         end
         heq_pkg::S_KREAD: begin
            state_in = heq_pkg::S_KWAIT;
         end
         heq_pkg::S_KWAIT: begin
            khead_in[cur_ff] = khead_ff[cur_ff] + 1'b1;
            kcount_in[cur_ff] = kcount_ff[cur_ff] - 1'b1;
            rsp_in.result_event = 32'(krdata);
            rsp_in.result_valid = 1'b1;
            rsp_in.source_queue = src_ff;
            done_in = 1'b1;
            state_in = heq_pkg::S_IDLE;
         end
         default: state_in = heq_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != heq_pkg::S_IDLE) || done_ff;
   assign done = done_ff;
   assign rsp = rsp_ff;
endmodule

/* rtl/hierarchical_event_queue_unit.sv */
// Top level of the hierarchical event queue unit
// channel | handshake               | payload
// req     | start & !busy           | req_payload (mode, queue_id, event_data)
// rsp     | rsp_strobe, no stall    | rsp_payload (event, valid, source, notify, status)
// csr     | csr_valid & csr_ready   | csr_data (notify_enable)
// Put or failed child get: answered in S_IDLE; busy holds while the result strobes.
// Parent get: S_PREAD, then S_PWAIT per entry read; a live link adds S_KREAD, S_KWAIT.
// Empty parent get: ends in S_PREAD, or in S_PWAIT after the last dead link is skipped.
// Child get: S_KREAD, then S_KWAIT; each wait state uses the registered queue RAM read.
// Reset clears all pointers, counts and skip counts at once; RAM contents stay undefined.
// The receiver cannot stall; busy holds off new requests while one is in flight.
`include "assert_macros.svh"
module hierarchical_event_queue_unit (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input heq_pkg::req_type req_payload,
   output logic rsp_strobe,
   output heq_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic csr_data
);
   logic notify_enable_ff;
   heq_pkg::pmem_ctl_type pctl;
   heq_pkg::kmem_ctl_type kctl;
   heq_pkg::pent_type prdata;
   logic [heq_pkg::EVENT_WIDTH-1:0] krdata;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         notify_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         notify_enable_ff <= csr_data;
      end
   end

   heq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req(req_payload),
      .notify_enable(notify_enable_ff), .busy(busy), .done(rsp_strobe),
      .rsp(rsp_payload), .pctl(pctl), .kctl(kctl), .prdata(prdata), .krdata(krdata)
   );

   heq_ram #(.WIDTH(heq_pkg::PEW), .AW(heq_pkg::PAW)) u_pram (
      .clock(clock), .we(pctl.we), .waddr(pctl.waddr), .wdata(pctl.wdata),
      .raddr(pctl.raddr), .rdata(prdata)
   );

   heq_ram #(.WIDTH(heq_pkg::EVENT_WIDTH), .AW(heq_pkg::KAW)) u_kram (
      .clock(clock), .we(kctl.we), .waddr(kctl.waddr), .wdata(kctl.wdata),
      .raddr(kctl.raddr), .rdata(krdata)
   );

   `ASSERT_NEXT(a_strobe_once, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_IMPLIES(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `ASSERT_IMPLIES(a_valid_ok, clock, reset, rsp_strobe && rsp_payload.result_valid,
      rsp_payload.status == heq_pkg::ST_OK)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
endmodule
